### design/lsl_pkg.sv
`default_nettype none

package lsl_pkg;

  // Fixed geometry of the lamp matrix and solenoid word
  localparam int LAMP_BYTES = 16;
  localparam int LAMP_IDX_W = 4;
  localparam int SOL_W      = 20;
  localparam int PADDR_W    = 3;

  // Defaults for the top-level parameters
  localparam int LAMP_SMOOTH_DEF = 2;
  localparam int SOL_SMOOTH_DEF  = 2;
  localparam int DISP_SMOOTH_DEF = 4;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Request function codes
  localparam logic [2:0] FN_PORT_A     = 3'd0;
  localparam logic [2:0] FN_STROBE_ONE = 3'd1;
  localparam logic [2:0] FN_STROBE_TWO = 3'd2;
  localparam logic [2:0] FN_SOLENOID   = 3'd3;
  localparam logic [2:0] FN_BANK_SEL   = 3'd4;
  localparam logic [2:0] FN_FRAME_TICK = 3'd5;
  localparam logic [2:0] FN_ZERO_CROSS = 3'd6;

  // Command codes passed from front to back
  localparam logic [1:0] OP_LAMP = 2'd0;
  localparam logic [1:0] OP_SOL  = 2'd1;
  localparam logic [1:0] OP_DIAG = 2'd2;
  localparam logic [1:0] OP_TICK = 2'd3;

  // Register word indexes on the APB port
  localparam logic REG_PHASE_MODE   = 1'b0;
  localparam logic REG_SECOND_BOARD = 1'b1;

  // Lamp address that strobes no lamp
  localparam logic [3:0] ADDR_IDLE = 4'hf;
  // Pulsed solenoid code that selects nothing
  localparam logic [3:0] PULSE_NONE = 4'hf;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] data;
  } in_item_t;

  typedef struct packed {
    logic                  lamp_valid;
    logic [LAMP_IDX_W-1:0] lamp_index;
    logic [7:0]            lamp_bits;
    logic [SOL_W-1:0]      solenoid_word;
    logic                  diag_led;
    logic                  last;
  } out_item_t;

  typedef struct packed {
    logic phase_mode;
    logic second_lamp_board;
  } cfg_t;

  // Fully resolved command; only the fields of its op are meaningful
  typedef struct packed {
    logic [1:0]       op;
    logic [3:0]       nib;
    logic [3:0]       addr_a;
    logic             board_a;
    logic [3:0]       addr_b;
    logic             en_b;
    logic [SOL_W-1:0] sol;
    logic             diag;
  } cmd_t;

  // True when a two-bit frame count is a multiple of period (1..4)
  function automatic logic smooth_hit(input logic [1:0] fc, input int period);
    logic [2:0] per;
    per = 3'(period);
    return (per == 3'd1) || (fc == 2'd0) || ({1'b0, fc} == per);
  endfunction

endpackage

`default_nettype wire

### design/lsl_front.sv
`default_nettype none

module lsl_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire lsl_pkg::cfg_t     cfg,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire lsl_pkg::in_item_t in_item,
  input  wire logic              q_full,
  output logic                   q_push,
  output lsl_pkg::cmd_t          q_cmd
);

  logic [7:0] port_a_latch;
  logic [3:0] lamp_addr_one;
  logic [3:0] lamp_addr_two;
  logic       strobe_one_line;
  logic       strobe_two_line;
  logic       bank_select_line;
  logic       mains_phase;
  logic       accept;
  logic       bit0;
  logic [15:0] pulse;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign bit0     = in_item.data[0];

  // Bus-side state: latch, strobe edges, bank select, mains phase
  always_ff @(posedge clk) begin
    if (rst) begin
      port_a_latch     <= '0;
      lamp_addr_one    <= '0;
      lamp_addr_two    <= '0;
      strobe_one_line  <= 1'b0;
      strobe_two_line  <= 1'b0;
      bank_select_line <= 1'b0;
      mains_phase      <= 1'b0;
    end else if (accept) begin
      unique case (in_item.func)
        lsl_pkg::FN_PORT_A: begin
          port_a_latch <= in_item.data;
        end
        lsl_pkg::FN_STROBE_ONE: begin
          if (strobe_one_line && !bit0) lamp_addr_one <= port_a_latch[3:0];
          strobe_one_line <= bit0;
        end
        lsl_pkg::FN_STROBE_TWO: begin
          if (strobe_two_line && !bit0) lamp_addr_two <= port_a_latch[3:0];
          strobe_two_line <= bit0;
        end
        lsl_pkg::FN_BANK_SEL: begin
          bank_select_line <= bit0;
        end
        lsl_pkg::FN_ZERO_CROSS: begin
          mains_phase <= !mains_phase;
        end
        default: begin
        end
      endcase
    end
  end

  // Pulsed line decode; bank select high or code fifteen selects none
  always_comb begin
    pulse = '0;
    if (!bank_select_line && in_item.data[3:0] != lsl_pkg::PULSE_NONE) begin
      pulse = 16'(16'd1 << in_item.data[3:0]);
    end
  end

  // Classify the request into a back-end command
  always_comb begin
    q_cmd         = '0;
    q_cmd.nib     = ~in_item.data[7:4];
    q_cmd.addr_a  = lamp_addr_one;
    q_cmd.board_a = cfg.phase_mode && mains_phase;
    q_cmd.addr_b  = lamp_addr_two;
    q_cmd.en_b    = !cfg.phase_mode && cfg.second_lamp_board;
    q_cmd.sol     = {~in_item.data[7:4], pulse};
    q_cmd.diag    = bit0;
    q_push        = 1'b0;
    unique case (in_item.func)
      lsl_pkg::FN_PORT_A: begin
        q_cmd.op = lsl_pkg::OP_LAMP;
        q_push   = accept;
      end
      lsl_pkg::FN_STROBE_TWO: begin
        q_cmd.op = lsl_pkg::OP_DIAG;
        q_push   = accept;
      end
      lsl_pkg::FN_SOLENOID: begin
        q_cmd.op = lsl_pkg::OP_SOL;
        q_push   = accept;
      end
      lsl_pkg::FN_FRAME_TICK: begin
        q_cmd.op = lsl_pkg::OP_TICK;
        q_push   = accept;
      end
      default: begin
        q_cmd.op = lsl_pkg::OP_LAMP;
      end
    endcase
  end

endmodule

`default_nettype wire

### design/lsl_queue.sv
`default_nettype none

module lsl_queue #(
  parameter int DEPTH = lsl_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire lsl_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               valid,
  output lsl_pkg::cmd_t      head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lsl_pkg::cmd_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic do_push;
  logic do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign valid   = (count != '0);
  assign head    = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_cmd;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

`default_nettype wire

### design/lsl_back.sv
`default_nettype none

module lsl_back #(
  parameter int LAMP_SMOOTH = lsl_pkg::LAMP_SMOOTH_DEF,
  parameter int SOL_SMOOTH  = lsl_pkg::SOL_SMOOTH_DEF,
  parameter int DISP_SMOOTH = lsl_pkg::DISP_SMOOTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  wire lsl_pkg::cmd_t q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output lsl_pkg::out_item_t out_item
);

  localparam logic ST_RUN  = 1'b0;
  localparam logic ST_EMIT = 1'b1;
  localparam logic [lsl_pkg::LAMP_IDX_W-1:0] IDX_LAST =
    lsl_pkg::LAMP_IDX_W'(lsl_pkg::LAMP_BYTES - 1);

  logic state;
  logic [lsl_pkg::LAMP_IDX_W-1:0] idx;
  logic [7:0] lamp_work [lsl_pkg::LAMP_BYTES];
  logic [7:0] lamp_next [lsl_pkg::LAMP_BYTES];
  logic [lsl_pkg::SOL_W-1:0] solenoid_accum;
  logic [lsl_pkg::SOL_W-1:0] pulsed_state;
  logic [lsl_pkg::SOL_W-1:0] solenoid_out;
  logic [lsl_pkg::SOL_W-1:0] solenoid_out_next;
  logic diag_work;
  logic diag_out;
  logic diag_out_next;
  logic [1:0] frame_count;
  logic [1:0] fc_next;
  logic hit_lamp;
  logic hit_sol;
  logic hit_disp;
  logic slot_free;
  logic pop_tick;
  logic emit_step;
  logic emit_done;
  logic [lsl_pkg::LAMP_IDX_W-1:0] pos_a;
  logic [lsl_pkg::LAMP_IDX_W-1:0] pos_b;
  logic [7:0] mask_a;
  logic [7:0] mask_b;

  assign slot_free = !out_valid || out_ready;
  // A tick needs the result slot; other commands never produce results
  assign q_pop = q_valid && (state == ST_RUN) &&
                 (q_cmd.op != lsl_pkg::OP_TICK || slot_free);
  assign pop_tick  = q_pop && q_cmd.op == lsl_pkg::OP_TICK;
  assign emit_step = (state == ST_EMIT) && slot_free;
  assign emit_done = emit_step && idx == IDX_LAST;

  // Frame tick schedule
  assign fc_next  = frame_count + 2'd1;
  assign hit_lamp = lsl_pkg::smooth_hit(fc_next, LAMP_SMOOTH);
  assign hit_sol  = lsl_pkg::smooth_hit(fc_next, SOL_SMOOTH);
  assign hit_disp = lsl_pkg::smooth_hit(fc_next, DISP_SMOOTH);
  assign solenoid_out_next = hit_sol ? solenoid_accum : solenoid_out;
  assign diag_out_next     = hit_disp ? diag_work : diag_out;

  // Lamp byte positions: (addr >> 3) + 8 * board, then stepped by 2 per data bit
  assign pos_a  = {q_cmd.board_a, 2'b00, q_cmd.addr_a[3]};
  assign pos_b  = {1'b1, 2'b00, q_cmd.addr_b[3]};
  assign mask_a = 8'(8'd1 << q_cmd.addr_a[2:0]);
  assign mask_b = 8'(8'd1 << q_cmd.addr_b[2:0]);

  // Lamp matrix update: OR on port A writes, clear after publication
  always_comb begin
    for (int i = 0; i < lsl_pkg::LAMP_BYTES; i++) lamp_next[i] = lamp_work[i];
    if (q_pop && q_cmd.op == lsl_pkg::OP_LAMP) begin
      for (int n = 0; n < 4; n++) begin
        if (q_cmd.nib[n] && q_cmd.addr_a != lsl_pkg::ADDR_IDLE) begin
          lamp_next[pos_a + lsl_pkg::LAMP_IDX_W'(2 * n)] =
            lamp_next[pos_a + lsl_pkg::LAMP_IDX_W'(2 * n)] | mask_a;
        end
        if (q_cmd.nib[n] && q_cmd.en_b && q_cmd.addr_b != lsl_pkg::ADDR_IDLE) begin
          lamp_next[pos_b + lsl_pkg::LAMP_IDX_W'(2 * n)] =
            lamp_next[pos_b + lsl_pkg::LAMP_IDX_W'(2 * n)] | mask_b;
        end
      end
    end
    if (emit_done) begin
      for (int i = 0; i < lsl_pkg::LAMP_BYTES; i++) lamp_next[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lsl_pkg::LAMP_BYTES; i++) lamp_work[i] <= '0;
    end else begin
      for (int i = 0; i < lsl_pkg::LAMP_BYTES; i++) lamp_work[i] <= lamp_next[i];
    end
  end

  // Solenoids, LED, frame counter and publication sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_RUN;
      idx            <= '0;
      solenoid_accum <= '0;
      pulsed_state   <= '0;
      solenoid_out   <= '0;
      diag_work      <= 1'b0;
      diag_out       <= 1'b0;
      frame_count    <= 2'd1;
      out_valid      <= 1'b0;
    end else begin
      if (emit_step || (pop_tick && !hit_lamp && (hit_sol || hit_disp))) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        unique case (q_cmd.op)
          lsl_pkg::OP_SOL: begin
            pulsed_state   <= q_cmd.sol;
            solenoid_accum <= solenoid_accum | q_cmd.sol;
          end
          lsl_pkg::OP_DIAG: begin
            diag_work <= q_cmd.diag;
          end
          lsl_pkg::OP_TICK: begin
            frame_count <= fc_next;
            if (hit_sol) begin
              solenoid_out   <= solenoid_accum;
              solenoid_accum <= pulsed_state;
            end
            if (hit_disp) begin
              diag_out  <= diag_work;
              diag_work <= 1'b0;
            end
            if (hit_lamp) begin
              state <= ST_EMIT;
              idx   <= '0;
            end
          end
          default: begin
          end
        endcase
      end
      if (emit_step) begin
        idx <= idx + 1'b1;
        if (emit_done) state <= ST_RUN;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (emit_step) begin
      out_item.lamp_valid    <= 1'b1;
      out_item.lamp_index    <= idx;
      out_item.lamp_bits     <= lamp_work[idx];
      out_item.solenoid_word <= solenoid_out;
      out_item.diag_led      <= diag_out;
      out_item.last          <= (idx == IDX_LAST);
    end else if (pop_tick) begin
      out_item.lamp_valid    <= 1'b0;
      out_item.lamp_index    <= '0;
      out_item.lamp_bits     <= '0;
      out_item.solenoid_word <= solenoid_out_next;
      out_item.diag_led      <= diag_out_next;
      out_item.last          <= 1'b1;
    end
  end

  // Publication blocks new commands
  assert property (@(posedge clk) disable iff (rst) (state == ST_EMIT) |-> !q_pop)
    else $error("command popped during lamp publication");

  // A lamp-publishing tick starts the sweep at byte zero
  assert property (@(posedge clk) disable iff (rst)
    (pop_tick && hit_lamp) |=> (state == ST_EMIT && idx == '0))
    else $error("lamp sweep did not start at byte zero");

  // The last byte ends the sweep and clears the matrix
  assert property (@(posedge clk) disable iff (rst)
    emit_done |=> (state == ST_RUN && lamp_work[0] == '0 && lamp_work[IDX_LAST] == '0))
    else $error("lamp sweep did not finish cleanly");

  // A result without lamp data is always a lone final result at index zero
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_item.lamp_valid) |-> (out_item.last && out_item.lamp_index == '0))
    else $error("malformed solenoid-only result");

endmodule

`default_nettype wire

### design/lamp_solenoid_latch_unit.sv
`default_nettype none

// Lamp and solenoid latch unit. Bus requests (port A writes, strobe and bank
// lines, solenoid writes, frame ticks, zero crossings) enter on the in channel;
// the front end resolves strobe edges, the latched port A byte and the board
// choice on the cycle a request is taken and queues a command, and the back end
// applies one command per cycle unless a lamp publication or a tick waiting
// for the result slot holds it, so bus requests run at one per cycle once the
// QUEUE_DEPTH-entry command queue is draining. A tick that publishes the lamp
// matrix holds the back end through all 16 bytes, one result each, and longer
// while out_ready is low; a tick that publishes only the solenoids or the LED
// gives a single result. The lamp matrix clears at reset, with no clearing pass.
// Configuration (phase_mode at byte address 0, second_lamp_board at 4) must be
// written over the APB port while the block is idle; the block does not enforce it.
module lamp_solenoid_latch_unit #(
  parameter int LAMP_SMOOTH = lsl_pkg::LAMP_SMOOTH_DEF,
  parameter int SOL_SMOOTH  = lsl_pkg::SOL_SMOOTH_DEF,
  parameter int DISP_SMOOTH = lsl_pkg::DISP_SMOOTH_DEF,
  parameter int QUEUE_DEPTH = lsl_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire lsl_pkg::in_item_t            in_item,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output lsl_pkg::out_item_t                out_item,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [lsl_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  lsl_pkg::cfg_t cfg;
  lsl_pkg::cmd_t push_cmd;
  lsl_pkg::cmd_t head_cmd;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_valid;
  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[lsl_pkg::PADDR_W-1];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        lsl_pkg::REG_PHASE_MODE:   cfg.phase_mode        <= pwdata[0];
        lsl_pkg::REG_SECOND_BOARD: cfg.second_lamp_board <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back
  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      lsl_pkg::REG_PHASE_MODE:   prdata[0] = cfg.phase_mode;
      lsl_pkg::REG_SECOND_BOARD: prdata[0] = cfg.second_lamp_board;
      default: begin
      end
    endcase
  end

  lsl_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  lsl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (head_cmd)
  );

  lsl_back #(
    .LAMP_SMOOTH (LAMP_SMOOTH),
    .SOL_SMOOTH  (SOL_SMOOTH),
    .DISP_SMOOTH (DISP_SMOOTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (head_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

### bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lsl_pkg::*;

  // Smoothing periods match the block's defaults
  localparam int LAMP_SMOOTH = LAMP_SMOOTH_DEF;
  localparam int SOL_SMOOTH  = SOL_SMOOTH_DEF;
  localparam int DISP_SMOOTH = DISP_SMOOTH_DEF;
  // Function code the block does not decode
  localparam logic [2:0] FN_UNUSED = 3'd7;
  // Cycles to let queued no-result requests drain before a register write
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_PER_PHASE = 89;

  logic clk;
  logic rst = 1'b1;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_item = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_item;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  lamp_solenoid_latch_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Bus requests waiting to go out, and results the board should publish
  in_item_t  bus_writes_q[$];
  out_item_t frame_results_q[$];

  logic steady = 1'b0;     // no idling on either side while set
  logic req_taken = 1'b0;
  int   fail_cnt = 0;
  int   sent_cnt = 0;
  int   checked_cnt = 0;
  int   lamp_frame_cnt = 0;
  int   config_cnt = 0;

  // Board state as the predictor sees it
  logic             cfg_phase;
  logic             cfg_second;
  logic [7:0]       port_a;
  logic [3:0]       addr_one;
  logic [3:0]       addr_two;
  logic             strobe_one;
  logic             strobe_two;
  logic             bank_sel;
  logic [7:0]       lamp_mat [LAMP_BYTES];
  logic [SOL_W-1:0] sol_accum;
  logic [SOL_W-1:0] sol_pulse;
  logic [SOL_W-1:0] sol_pub;
  logic             diag_pend;
  logic             diag_pub;
  logic [1:0]       frame_cnt;
  logic             mains_phase;

  function automatic void clear_board();
    cfg_phase = 1'b0;
    cfg_second = 1'b0;
    port_a = '0;
    addr_one = '0;
    addr_two = '0;
    strobe_one = 1'b0;
    strobe_two = 1'b0;
    bank_sel = 1'b0;
    for (int i = 0; i < LAMP_BYTES; i++) lamp_mat[i] = '0;
    sol_accum = '0;
    sol_pulse = '0;
    sol_pub = '0;
    diag_pend = 1'b0;
    diag_pub = 1'b0;
    frame_cnt = 2'd1;
    mains_phase = 1'b0;
  endfunction

  // OR the active-low data nibble into the matrix for one board/address
  function automatic void light_lamps(logic board, logic [3:0] addr);
    logic [3:0] nib;
    int         base;
    if (addr == ADDR_IDLE) return;
    nib = ~port_a[7:4];
    base = int'(addr[3]) + 8 * int'(board);
    for (int n = 0; n < 4; n++)
      if (nib[n]) lamp_mat[(base + 2 * n) % LAMP_BYTES][addr[2:0]] = 1'b1;
  endfunction

  // Frame tick: publish and clear whatever this frame count selects
  function automatic void publish_frame();
    logic       do_lamps;
    logic       do_sols;
    logic       do_diag;
    logic [7:0] snap [LAMP_BYTES];
    out_item_t  res;
    frame_cnt = frame_cnt + 2'd1;
    do_lamps = (int'(frame_cnt) % LAMP_SMOOTH) == 0;
    do_sols  = (int'(frame_cnt) % SOL_SMOOTH) == 0;
    do_diag  = (int'(frame_cnt) % DISP_SMOOTH) == 0;
    for (int i = 0; i < LAMP_BYTES; i++) begin
      snap[i] = lamp_mat[i];
      if (do_lamps) lamp_mat[i] = '0;
    end
    if (do_sols) begin
      sol_pub = sol_accum;
      sol_accum = sol_pulse;
    end
    if (do_diag) begin
      diag_pub = diag_pend;
      diag_pend = 1'b0;
    end
    res.solenoid_word = sol_pub;
    res.diag_led = diag_pub;
    if (do_lamps) begin
      for (int i = 0; i < LAMP_BYTES; i++) begin
        res.lamp_valid = 1'b1;
        res.lamp_index = LAMP_IDX_W'(i);
        res.lamp_bits = snap[i];
        res.last = (i == LAMP_BYTES - 1);
        frame_results_q.push_back(res);
      end
    end else if (do_sols || do_diag) begin
      res.lamp_valid = 1'b0;
      res.lamp_index = '0;
      res.lamp_bits = '0;
      res.last = 1'b1;
      frame_results_q.push_back(res);
    end
  endfunction

  // Apply one accepted bus request to the board state
  function automatic void apply_bus_request(in_item_t req);
    logic [SOL_W-1:0] pulse;
    case (req.func)
      FN_PORT_A: begin
        port_a = req.data;
        if (cfg_phase) begin
          light_lamps(mains_phase, addr_one);
        end else begin
          light_lamps(1'b0, addr_one);
          if (cfg_second) light_lamps(1'b1, addr_two);
        end
      end
      FN_STROBE_ONE: begin
        if (strobe_one && !req.data[0]) addr_one = port_a[3:0];
        strobe_one = req.data[0];
      end
      FN_STROBE_TWO: begin
        if (strobe_two && !req.data[0]) addr_two = port_a[3:0];
        strobe_two = req.data[0];
        diag_pend = req.data[0];
      end
      FN_SOLENOID: begin
        pulse = '0;
        if (!bank_sel && req.data[3:0] != PULSE_NONE) pulse[req.data[3:0]] = 1'b1;
        pulse[19:16] = ~req.data[7:4];
        sol_pulse = pulse;
        sol_accum = sol_accum | pulse;
      end
      FN_BANK_SEL: bank_sel = req.data[0];
      FN_FRAME_TICK: publish_frame();
      FN_ZERO_CROSS: mains_phase = ~mains_phase;
      default: ;
    endcase
  endfunction

  // Request driver: accept at the rising edge, present the next at the falling edge
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      apply_bus_request(in_item);
      req_taken = 1'b1;
      sent_cnt++;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      req_taken = 1'b0;
      if (bus_writes_q.size() > 0 && (steady || $urandom_range(99) >= 22)) begin
        in_item <= bus_writes_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side backpressure
  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 22);
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_cnt++;
    end
  endfunction

  // Result monitor
  out_item_t want;
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (frame_results_q.size() == 0) begin
        $error("result with nothing expected: 0x%0h", out_item);
        fail_cnt++;
      end else begin
        want = frame_results_q.pop_front();
        check_field("lamp_valid", 32'(want.lamp_valid), 32'(out_item.lamp_valid));
        check_field("lamp_index", 32'(want.lamp_index), 32'(out_item.lamp_index));
        check_field("lamp_bits", 32'(want.lamp_bits), 32'(out_item.lamp_bits));
        check_field("solenoid_word", 32'(want.solenoid_word),
                    32'(out_item.solenoid_word));
        check_field("diag_led", 32'(want.diag_led), 32'(out_item.diag_led));
        check_field("last", 32'(want.last), 32'(out_item.last));
        checked_cnt++;
        if (want.lamp_valid && want.last) lamp_frame_cnt++;
      end
    end
  end

  function automatic void queue_req(logic [2:0] fn, logic [7:0] value);
    in_item_t req;
    req.func = fn;
    req.data = value;
    bus_writes_q.push_back(req);
  endfunction

  // Wait until the board has gone quiet
  task automatic wait_drained();
    do @(negedge clk);
    while (bus_writes_q.size() != 0 || in_valid || frame_results_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_PHASE_MODE) cfg_phase = value[0];
    else cfg_second = value[0];
  endtask

  task automatic set_config(input logic phase_sel, input logic two_boards);
    write_reg(REG_PHASE_MODE, {31'd0, phase_sel});
    write_reg(REG_SECOND_BOARD, {31'd0, two_boards});
    config_cnt++;
  endtask

  // Mostly address-latch sequences followed by lamp data, plus loose noise
  task automatic queue_random(input int target);
    int         cnt;
    int         pick;
    logic [2:0] strobe_fn;
    cnt = 0;
    while (cnt < target) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        strobe_fn = $urandom_range(1) ? FN_STROBE_ONE : FN_STROBE_TWO;
        queue_req(FN_PORT_A, 8'($urandom_range(255)));
        queue_req(strobe_fn, 8'($urandom_range(255)) | 8'h01);
        queue_req(strobe_fn, 8'($urandom_range(255)) & 8'hfe);
        repeat ($urandom_range(1, 3)) begin
          queue_req(FN_PORT_A, 8'($urandom_range(255)));
          cnt++;
        end
        cnt += 3;
      end else if (pick < 52) begin
        if ($urandom_range(3) == 0) begin
          queue_req(FN_BANK_SEL, 8'($urandom_range(255)));
          cnt++;
        end
        queue_req(FN_SOLENOID, 8'($urandom_range(255)));
        cnt++;
      end else if (pick < 68) begin
        queue_req(FN_FRAME_TICK, 8'($urandom_range(255)));
        cnt++;
      end else if (pick < 76) begin
        queue_req(FN_ZERO_CROSS, 8'($urandom_range(255)));
        cnt++;
      end else begin
        queue_req(3'($urandom_range(7)), 8'($urandom_range(255)));
        cnt++;
      end
    end
  endtask

  initial begin
    clear_board();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_config(1'b0, 1'b1);
    // Directed: full and empty lamp nibbles on both boards, address latching
    queue_req(FN_PORT_A, 8'h00);
    queue_req(FN_STROBE_ONE, 8'hff);
    queue_req(FN_PORT_A, 8'h5a);
    queue_req(FN_STROBE_ONE, 8'h00);
    queue_req(FN_STROBE_TWO, 8'hff);
    queue_req(FN_PORT_A, 8'hff);
    // idle address on board two
    queue_req(FN_STROBE_TWO, 8'hfe);
    queue_req(FN_PORT_A, 8'h07);
    // Solenoids: lowest code, no-pulse code, bank high, plain
    queue_req(FN_SOLENOID, 8'h00);
    queue_req(FN_SOLENOID, 8'hff);
    queue_req(FN_BANK_SEL, 8'h01);
    queue_req(FN_SOLENOID, 8'h3e);
    queue_req(FN_BANK_SEL, 8'h00);
    queue_req(FN_SOLENOID, 8'h0e);
    queue_req(FN_UNUSED, 8'haa);
    queue_req(FN_ZERO_CROSS, 8'h55);
    // Walk the frame counter through all four phases, LED set on the way
    queue_req(FN_FRAME_TICK, 8'h00);
    queue_req(FN_FRAME_TICK, 8'hff);
    queue_req(FN_STROBE_TWO, 8'h01);
    queue_req(FN_FRAME_TICK, 8'h00);
    queue_req(FN_FRAME_TICK, 8'h00);
    queue_req(FN_FRAME_TICK, 8'h00);
    queue_req(FN_ZERO_CROSS, 8'h00);
    wait_drained();

    // Random phases; the sender sits idle between them until all results are in
    queue_random(RANDOM_PER_PHASE);
    wait_drained();
    set_config(1'b0, 1'b0);
    steady = 1'b1;
    queue_random(RANDOM_PER_PHASE);
    wait_drained();
    steady = 1'b0;
    set_config(1'b1, 1'b0);
    queue_random(RANDOM_PER_PHASE);
    wait_drained();
    set_config(1'b1, 1'b1);
    queue_random(RANDOM_PER_PHASE);
    wait_drained();

    if (frame_results_q.size() != 0) begin
      $error("%0d results never arrived", frame_results_q.size());
      fail_cnt++;
    end
    $display("Sent %0d bus requests across %0d register settings; checked %0d results",
             sent_cnt, config_cnt, checked_cnt);
    $display("including %0d full lamp matrix frames", lamp_frame_cnt);
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
